[sv/gpa_pkg.sv]
// Shared types and constants of the GF(256) parity accumulator.
package gpa_pkg;

  localparam int DEF_MAX_ROWS   = 8;
  localparam int DEF_MAX_LENGTH = 1024;
  localparam int TABLE_BYTES    = 32;
  localparam int ROW_FW         = 3;
  localparam int TIDX_FW        = 5;
  localparam int OFF_FW         = 10;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 4;
  localparam logic [CNT_W-1:0] ACTIVE_ROWS_RST = 4'd1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PRESET = 2'd1,
    OP_ACCUM  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

[sv/gpa_table_ram.sv]
// Nibble product table memory: one write port, two registered read ports.
module gpa_table_ram
  import gpa_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_ROWS * TABLE_BYTES,
  parameter int ADDR_W = $clog2(DEF_MAX_ROWS * TABLE_BYTES)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_lo,
  input  logic [ADDR_W-1:0] rd_addr_hi,
  output logic [BYTE_W-1:0] rd_data_lo,
  output logic [BYTE_W-1:0] rd_data_hi
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_lo <= mem[rd_addr_lo];
      rd_data_hi <= mem[rd_addr_hi];
    end
  end

endmodule

[sv/gpa_parity_ram.sv]
// Parity byte memory: one write port, one registered read port.
module gpa_parity_ram
  import gpa_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_LENGTH,
  parameter int ADDR_W = $clog2(DEF_MAX_ROWS * DEF_MAX_LENGTH)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/gf256_parity_accumulate_top.sv]
// Top level of the GF(256) split-nibble parity accumulator.
//
// Usage: items arrive on the in_ channel (in_valid / in_stall) and results
// leave on the out_ channel (out_valid / out_stall); a transfer happens at a
// clock edge where valid is high and stall is low. An item loads one table
// byte, presets one parity byte, accumulates a source byte into the active
// parity rows, or reads one parity byte back. An accumulate at a valid offset
// gives one result per active row in row order, the last one flagged by
// out_last; a read gives exactly one result. The user must write the register
// active_rows through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this. A new item is taken once the
// previous one has issued all its reads, and an accumulate does one
// read-modify-write of the parity memory per active row. The first result of
// an item passes the item registers, the read stage and the output register
// before it shows on out_valid. When the receiver stalls, the result waits in
// the output register, the next row's memory data waits in the read stage,
// and the sequencer stops issuing reads, so nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties all stages and sets active_rows
// to 1; the memories are not cleared and must be written before being read.
module gf256_parity_accumulate_top
  import gpa_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [ROW_FW-1:0] in_row_select,
  input  logic [TIDX_FW-1:0] in_table_index,
  input  logic [BYTE_W-1:0] in_table_byte,
  input  logic [BYTE_W-1:0] in_preset_byte,
  input  logic [BYTE_W-1:0] in_source_byte,
  input  logic [OFF_FW-1:0] in_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROW_FW-1:0] out_row,
  output logic [OFF_FW-1:0] out_offset,
  output logic [BYTE_W-1:0] out_parity_value,
  output logic              out_last
);

  // Only rows and offsets that the port fields can address get storage.
  localparam int ROW_CAP   = (MAX_ROWS < 8) ? MAX_ROWS : 8;
  localparam int LEN_CAP   = (MAX_LENGTH < 1024) ? MAX_LENGTH : 1024;
  localparam int TDEPTH    = ROW_CAP * TABLE_BYTES;
  localparam int TA_W      = $clog2(TDEPTH);
  localparam int PDEPTH    = ROW_CAP * LEN_CAP;
  localparam int PA_W      = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

  // Configuration register.
  logic [CNT_W-1:0] active_rows_r;

  // Current item being worked on.
  state_t            state_r, state_nxt;
  op_t               job_op_r;
  logic [ROW_FW-1:0] job_row_r;
  logic [TIDX_FW-1:0] job_tidx_r;
  logic [BYTE_W-1:0] job_tbyte_r;
  logic [BYTE_W-1:0] job_pbyte_r;
  logic [BYTE_W-1:0] job_src_r;
  logic [OFF_FW-1:0] job_off_r;
  logic              job_ok_r;
  logic              job_skip_r;
  logic [CNT_W-1:0]  job_n_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Read stage: memory data of the row being finished.
  logic              s1_valid_r;
  logic [ROW_FW-1:0] s1_row_r;
  logic [OFF_FW-1:0] s1_off_r;
  logic [PA_W-1:0]   s1_addr_r;
  logic              s1_acc_r;
  logic              s1_zero_r;
  logic              s1_last_r;

  // Output register.
  logic              out_valid_r;
  logic [ROW_FW-1:0] out_row_r;
  logic [OFF_FW-1:0] out_offset_r;
  logic [BYTE_W-1:0] out_value_r;
  logic              out_last_r;

  logic              out_free, s1_adv, s1_free, accept;
  logic              row_ok_in, off_ok_in;
  logic [CNT_W-1:0]  n_in;
  logic              s1_load, s1_load_acc, s1_load_last;
  logic [ROW_FW-1:0] s1_load_row;
  logic [PA_W-1:0]   issue_addr;
  logic [BYTE_W-1:0] s1_value;

  mem_ctl_t          tbl_ctl, par_ctl;
  logic [TA_W-1:0]   tbl_wr_addr, tbl_rd_lo, tbl_rd_hi;
  logic [BYTE_W-1:0] tbl_lo, tbl_hi, par_rd_data, par_wr_data;
  logic [PA_W-1:0]   par_wr_addr;
  logic              preset_wr;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || s1_adv;

  // A new item is taken once the previous one has issued all its reads and
  // its final write-back leaves the read stage in this cycle at the latest.
  assign in_stall = !((state_r == ST_IDLE) && s1_free);
  assign accept   = in_valid && !in_stall;

  assign row_ok_in = 32'(in_row_select) < MAX_ROWS;
  assign off_ok_in = 32'(in_offset) < MAX_LENGTH;
  assign n_in      = (32'(active_rows_r) > ROW_CAP) ? CNT_W'(ROW_CAP) : active_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= ACTIVE_ROWS_RST;
    end else if (cfg_we) begin
      active_rows_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Item capture. Accumulate ignores the row field, preset and read need both.
  always_ff @(posedge clk) begin
    if (accept) begin
      job_op_r    <= op_t'(in_op);
      job_row_r   <= in_row_select;
      job_tidx_r  <= in_table_index;
      job_tbyte_r <= in_table_byte;
      job_pbyte_r <= in_preset_byte;
      job_src_r   <= in_source_byte;
      job_off_r   <= in_offset;
      job_n_r     <= n_in;
      job_skip_r  <= !off_ok_in || (n_in == '0);
      unique case (op_t'(in_op))
        OP_LOAD:  job_ok_r <= row_ok_in;
        OP_ACCUM: job_ok_r <= off_ok_in;
        default:  job_ok_r <= row_ok_in && off_ok_in;
      endcase
    end
  end

  // Sequencer: load and preset write from the run state, a read issues one read, an accumulate one read per row.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    s1_load      = 1'b0;
    s1_load_acc  = 1'b0;
    s1_load_last = 1'b1;
    s1_load_row  = job_row_r;
    issue_addr   = PA_W'(32'(job_row_r) * LEN_CAP + 32'(job_off_r));
    tbl_ctl      = '0;
    preset_wr    = 1'b0;
    par_ctl.rd_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (job_op_r)
          OP_LOAD: begin
            tbl_ctl.wr_en = job_ok_r;
            state_nxt     = ST_IDLE;
          end
          OP_PRESET: begin
            preset_wr = job_ok_r;
            state_nxt = ST_IDLE;
          end
          OP_READ: begin
            if (s1_free) begin
              s1_load       = 1'b1;
              par_ctl.rd_en = job_ok_r;
              state_nxt     = ST_IDLE;
            end
          end
          OP_ACCUM: begin
            s1_load_row = cnt_r[ROW_FW-1:0];
            issue_addr  = PA_W'(32'(cnt_r[ROW_FW-1:0]) * LEN_CAP + 32'(job_off_r));
            if (job_skip_r) begin
              state_nxt = ST_IDLE;
            end else if (s1_free) begin
              s1_load       = 1'b1;
              s1_load_acc   = 1'b1;
              s1_load_last  = (CNT_W'(cnt_r + 1'b1) == job_n_r);
              par_ctl.rd_en = 1'b1;
              tbl_ctl.rd_en = 1'b1;
              cnt_nxt       = CNT_W'(cnt_r + 1'b1);
              if (s1_load_last) begin
                state_nxt = ST_IDLE;
              end
            end
          end
        endcase
      end
    endcase
    // Write-back of an accumulated row, or a preset; never both in one cycle.
    par_ctl.wr_en = (s1_adv && s1_acc_r) || preset_wr;
  end

  assign tbl_wr_addr = TA_W'({job_row_r, job_tidx_r});
  assign tbl_rd_lo   = TA_W'({cnt_r[ROW_FW-1:0], 1'b0, job_src_r[3:0]});
  assign tbl_rd_hi   = TA_W'({cnt_r[ROW_FW-1:0], 1'b1, job_src_r[7:4]});

  // Read stage. The memory output registers hold while the stage waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_row_r  <= s1_load_row;
      s1_off_r  <= job_off_r;
      s1_addr_r <= issue_addr;
      s1_acc_r  <= s1_load_acc;
      s1_zero_r <= !job_ok_r;
      s1_last_r <= s1_load_last;
    end
  end

  always_comb begin
    if (s1_zero_r) begin
      s1_value = '0;
    end else if (s1_acc_r) begin
      s1_value = par_rd_data ^ tbl_lo ^ tbl_hi;
    end else begin
      s1_value = par_rd_data;
    end
  end

  // Address and data of the parity write: the pending row, else the preset.
  always_comb begin
    if (s1_adv && s1_acc_r) begin
      par_wr_addr = s1_addr_r;
      par_wr_data = s1_value;
    end else begin
      par_wr_addr = issue_addr;
      par_wr_data = job_pbyte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_row_r    <= s1_row_r;
      out_offset_r <= s1_off_r;
      out_value_r  <= s1_value;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_offset       = out_offset_r;
  assign out_parity_value = out_value_r;
  assign out_last         = out_last_r;

  gpa_table_ram #(
    .DEPTH  (TDEPTH),
    .ADDR_W (TA_W)
  ) u_table_ram (
    .clk        (clk),
    .ctl        (tbl_ctl),
    .wr_addr    (tbl_wr_addr),
    .wr_data    (job_tbyte_r),
    .rd_addr_lo (tbl_rd_lo),
    .rd_addr_hi (tbl_rd_hi),
    .rd_data_lo (tbl_lo),
    .rd_data_hi (tbl_hi)
  );

  gpa_parity_ram #(
    .DEPTH  (PDEPTH),
    .ADDR_W (PA_W)
  ) u_parity_ram (
    .clk     (clk),
    .ctl     (par_ctl),
    .wr_addr (par_wr_addr),
    .wr_data (par_wr_data),
    .rd_addr (issue_addr),
    .rd_data (par_rd_data)
  );

  // A preset never collides with a pending row write-back.
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    preset_wr |-> !(s1_adv && s1_acc_r))
    else $error("preset write collides with accumulate write-back");

  // After an item is taken, the read stage has drained its last row.
  a_drained_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !s1_valid_r)
    else $error("read stage still busy after accepting an item");

  // The row counter stays below the row count of the running accumulate.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && job_op_r == OP_ACCUM && !job_skip_r) |-> (cnt_r < job_n_r))
    else $error("row counter beyond active rows");

  // A waiting row in the read stage is kept while the output is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_row_r) && $stable(s1_last_r)))
    else $error("read stage lost a row under stall");

  // No new read is issued while the read stage is blocked.
  a_no_issue_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |-> !par_ctl.rd_en)
    else $error("parity read issued into a blocked read stage");

endmodule

[sim/gpa_tb_pkg.sv]
`timescale 1ns / 1ps
// Transfer types and the parity scoreboard class of the accumulator testbench.
package gpa_tb_pkg;
  import gpa_pkg::*;

  typedef struct {
    op_t                op;
    logic [ROW_FW-1:0]  row_select;
    logic [TIDX_FW-1:0] table_index;
    logic [BYTE_W-1:0]  table_byte;
    logic [BYTE_W-1:0]  preset_byte;
    logic [BYTE_W-1:0]  source_byte;
    logic [OFF_FW-1:0]  offset;
  } gpa_item_t;

  typedef struct {
    logic [ROW_FW-1:0] row;
    logic [OFF_FW-1:0] offset;
    logic [BYTE_W-1:0] value;
    logic              last;
  } parity_result_t;

  class parity_scoreboard;
    logic [BYTE_W-1:0] product_tables [DEF_MAX_ROWS][TABLE_BYTES];
    logic [BYTE_W-1:0] parity_bytes [DEF_MAX_ROWS][DEF_MAX_LENGTH];
    logic [CNT_W-1:0]  rows_active;
    parity_result_t    expected_parity_q[$];
    int                failures;

    function new();
      foreach (product_tables[r, i]) product_tables[r][i] = '0;
      foreach (parity_bytes[r, i]) parity_bytes[r][i] = '0;
      rows_active = ACTIVE_ROWS_RST;
      failures    = 0;
    endfunction

    function void set_active_rows(logic [CNT_W-1:0] value);
      rows_active = value;
    endfunction

    function int pending();
      return expected_parity_q.size();
    endfunction

    // Updates the stores for one accepted transfer and queues its results.
    function void note_transfer(gpa_item_t it);
      int                n;
      bit                row_ok;
      bit                off_ok;
      logic [BYTE_W-1:0] product;
      parity_result_t    res;
      row_ok = int'(it.row_select) < DEF_MAX_ROWS;
      off_ok = int'(it.offset) < DEF_MAX_LENGTH;
      case (it.op)
        OP_LOAD: begin
          if (row_ok) product_tables[it.row_select][it.table_index] = it.table_byte;
        end
        OP_PRESET: begin
          if (row_ok && off_ok) parity_bytes[it.row_select][it.offset] = it.preset_byte;
        end
        OP_ACCUM: begin
          // The row count saturates at eight rows.
          n = (int'(rows_active) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_active);
          if (off_ok) begin
            for (int r = 0; r < n; r++) begin
              product = product_tables[r][it.source_byte[3:0]]
                      ^ product_tables[r][TABLE_BYTES / 2 + int'(it.source_byte[7:4])];
              parity_bytes[r][it.offset] = parity_bytes[r][it.offset] ^ product;
              res.row    = ROW_FW'(r);
              res.offset = it.offset;
              res.value  = parity_bytes[r][it.offset];
              res.last   = (r + 1 == n);
              expected_parity_q.push_back(res);
            end
          end
        end
        default: begin
          res.row    = it.row_select;
          res.offset = it.offset;
          res.value  = (row_ok && off_ok) ? parity_bytes[it.row_select][it.offset] : '0;
          res.last   = 1'b1;
          expected_parity_q.push_back(res);
        end
      endcase
    endfunction

    function void check_result(parity_result_t got);
      parity_result_t want;
      if (expected_parity_q.size() == 0) begin
        $error("unexpected result: row %0d offset %0d value 0x%02h last %0b",
               got.row, got.offset, got.value, got.last);
        failures++;
        return;
      end
      want = expected_parity_q.pop_front();
      if (got.row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, got.row);
        failures++;
      end
      if (got.offset !== want.offset) begin
        $error("out_offset: expected %0d, got %0d", want.offset, got.offset);
        failures++;
      end
      if (got.value !== want.value) begin
        $error("out_parity_value: expected 0x%02h, got 0x%02h", want.value, got.value);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench of the GF(256) parity accumulator.
module tb_top;
  import gpa_pkg::*;
  import gpa_tb_pkg::*;

  // Random operations per register setting. Together with the table fill,
  // the directed part and the presets that go before accumulates, the run
  // sends about 380 items.
  localparam int RANDOM_PER_PHASE = 7;
  // Cycles that a table load or a preset may still be in flight after the
  // last expected result has been seen, with margin.
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 20;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_op;
  logic [ROW_FW-1:0]  in_row_select;
  logic [TIDX_FW-1:0] in_table_index;
  logic [BYTE_W-1:0]  in_table_byte;
  logic [BYTE_W-1:0]  in_preset_byte;
  logic [BYTE_W-1:0]  in_source_byte;
  logic [OFF_FW-1:0]  in_offset;
  logic               out_valid;
  logic               out_stall;
  logic [ROW_FW-1:0]  out_row;
  logic [OFF_FW-1:0]  out_offset;
  logic [BYTE_W-1:0]  out_parity_value;
  logic               out_last;

  parity_scoreboard sb;

  // Parity bytes that have been preset at least once. Reading a parity byte
  // that was never written is outside the contract of the block, so every
  // read and every accumulate is preceded by presets where this is clear.
  // All table bytes are loaded at the start, so tables need no such map.
  bit parity_written [DEF_MAX_ROWS][DEF_MAX_LENGTH];

  // Most traffic lands on a small set of offsets so that accumulates hit
  // bytes that already hold earlier sums.
  logic [OFF_FW-1:0] offset_pool [4];

  // Remaining length of a burst without idle cycles, one per side.
  int in_quiet;
  int out_quiet;

  gf256_parity_accumulate_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_row_select    (in_row_select),
    .in_table_index   (in_table_index),
    .in_table_byte    (in_table_byte),
    .in_preset_byte   (in_preset_byte),
    .in_source_byte   (in_source_byte),
    .in_offset        (in_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_offset       (out_offset),
    .out_parity_value (out_parity_value),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Number of idle cycles before the next transfer, drawn at random, with
  // occasional stretches where the side never idles.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Every field gets a random value; the caller overrides the ones that the
  // operation uses. The block must ignore the rest.
  function automatic gpa_item_t random_fields();
    gpa_item_t it;
    it.op          = op_t'($urandom_range(0, 3));
    it.row_select  = ROW_FW'($urandom_range(0, DEF_MAX_ROWS - 1));
    it.table_index = TIDX_FW'($urandom_range(0, TABLE_BYTES - 1));
    it.table_byte  = BYTE_W'($urandom_range(0, 255));
    it.preset_byte = BYTE_W'($urandom_range(0, 255));
    it.source_byte = BYTE_W'($urandom_range(0, 255));
    it.offset      = OFF_FW'($urandom_range(0, DEF_MAX_LENGTH - 1));
    return it;
  endfunction

  function automatic logic [OFF_FW-1:0] pick_offset();
    if ($urandom_range(0, 99) < 90) return offset_pool[$urandom_range(0, 3)];
    return OFF_FW'($urandom_range(0, DEF_MAX_LENGTH - 1));
  endfunction

  // Drives one item and returns at the clock edge of its transfer. Valid is
  // left high so that a following item can go out without a gap; the caller
  // or the next gap lowers it.
  task automatic send_item(gpa_item_t it);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_row_select  <= it.row_select;
    in_table_index <= it.table_index;
    in_table_byte  <= it.table_byte;
    in_preset_byte <= it.preset_byte;
    in_source_byte <= it.source_byte;
    in_offset      <= it.offset;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(it);
    if (it.op == OP_PRESET) parity_written[it.row_select][it.offset] = 1'b1;
  endtask

  // One operation: value is the table byte of a load, the parity byte of a
  // preset or the source byte of an accumulate.
  task automatic issue(op_t op, int row, int tidx, int value, int off);
    gpa_item_t it;
    it            = random_fields();
    it.op         = op;
    it.row_select = ROW_FW'(row);
    it.offset     = OFF_FW'(off);
    case (op)
      OP_LOAD: begin
        it.table_index = TIDX_FW'(tidx);
        it.table_byte  = BYTE_W'(value);
      end
      OP_PRESET: it.preset_byte = BYTE_W'(value);
      OP_ACCUM:  it.source_byte = BYTE_W'(value);
      default: ;
    endcase
    send_item(it);
  endtask

  // Presets every row at an offset that has not been written yet, so that an
  // accumulate there reads only defined parity bytes.
  task automatic prepare_offset(int off);
    for (int r = 0; r < DEF_MAX_ROWS; r++) begin
      if (!parity_written[r][off]) issue(OP_PRESET, r, 0, $urandom_range(0, 255), off);
    end
  endtask

  task automatic read_parity(int row, int off);
    if (!parity_written[row][off]) issue(OP_PRESET, row, 0, $urandom_range(0, 255), off);
    issue(OP_READ, row, 0, 0, off);
  endtask

  // The register may only change while the block is idle: every expected
  // result must have arrived, and loads or presets still in flight must have
  // had time to finish.
  task automatic program_active_rows(int value);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_active_rows(CNT_W'(value));
  endtask

  // Mostly accumulates on prepared offsets with random source bytes, mixed
  // with table reloads, presets and read-backs.
  task automatic run_random(int count);
    int pick;
    int row;
    int off;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      row  = $urandom_range(0, DEF_MAX_ROWS - 1);
      off  = pick_offset();
      if (pick < 12) begin
        issue(OP_LOAD, row, $urandom_range(0, TABLE_BYTES - 1), $urandom_range(0, 255), off);
      end else if (pick < 24) begin
        issue(OP_PRESET, row, 0, $urandom_range(0, 255), off);
      end else if (pick < 70) begin
        prepare_offset(off);
        issue(OP_ACCUM, row, 0, $urandom_range(0, 255), off);
      end else begin
        read_parity(row, off);
      end
    end
  endtask

  // Receiver: stalls for a random number of cycles before each result, and
  // the stall is released whether or not a result is waiting, so stalls
  // land on every phase of the block's work.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result monitor: values read right after the edge are those the block
  // presented before it, which is when the transfer took place.
  initial begin
    parity_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.row    = out_row;
        got.offset = out_offset;
        got.value  = out_parity_value;
        got.last   = out_last;
        sb.check_result(got);
      end
    end
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int rows_plan [8];
    sb        = new();
    rows_plan = '{8, 0, 15, 1, 5, 10, 9, 3};
    in_quiet  = 0;
    out_quiet = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_op          <= OP_LOAD;
    in_row_select  <= '0;
    in_table_index <= '0;
    in_table_byte  <= '0;
    in_preset_byte <= '0;
    in_source_byte <= '0;
    in_offset      <= '0;
    out_stall      <= 1'b0;
    offset_pool[0] = '0;
    offset_pool[1] = OFF_FW'(DEF_MAX_LENGTH - 1);
    for (int i = 2; i < 4; i++) offset_pool[i] = OFF_FW'($urandom_range(0, DEF_MAX_LENGTH - 1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every nibble table; the first and last byte of each row get the
    // extreme value 0xFF in even rows and 0x00 in odd rows.
    for (int r = 0; r < DEF_MAX_ROWS; r++) begin
      for (int i = 0; i < TABLE_BYTES; i++) begin
        if (i == 0 || i == TABLE_BYTES - 1)
          issue(OP_LOAD, r, i, (r % 2 == 0) ? 8'hFF : 8'h00, $urandom_range(0, 1023));
        else
          issue(OP_LOAD, r, i, $urandom_range(0, 255), $urandom_range(0, 1023));
      end
    end
    prepare_offset(0);
    prepare_offset(DEF_MAX_LENGTH - 1);

    // Directed part at the reset setting of one active row: extreme parity
    // values, table reloads at both ends, source bytes with an empty or a
    // full nibble, and read-back from the corner rows and offsets.
    issue(OP_PRESET, 0, 0, 8'hFF, 0);
    issue(OP_PRESET, DEF_MAX_ROWS - 1, 0, 8'h00, DEF_MAX_LENGTH - 1);
    issue(OP_LOAD, 0, 0, 8'h00, 0);
    issue(OP_LOAD, 0, TABLE_BYTES - 1, 8'hFF, 0);
    issue(OP_ACCUM, 0, 0, 8'h00, 0);
    issue(OP_ACCUM, 0, 0, 8'hFF, 0);
    issue(OP_ACCUM, 0, 0, 8'h0F, DEF_MAX_LENGTH - 1);
    issue(OP_ACCUM, 0, 0, 8'hF0, DEF_MAX_LENGTH - 1);
    read_parity(0, 0);
    read_parity(DEF_MAX_ROWS - 1, DEF_MAX_LENGTH - 1);
    read_parity(DEF_MAX_ROWS - 1, 0);
    read_parity(0, DEF_MAX_LENGTH - 1);

    // Random phases over a sweep of row counts: full width, none, a value
    // past the saturation point, and values in between.
    foreach (rows_plan[p]) begin
      program_active_rows(rows_plan[p]);
      run_random(RANDOM_PER_PHASE);
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
